// ===== src/ptc_pkg.sv =====
// Package for the prime test and count unit.
// Holds field widths, request codes, the sequencer state type and defaults.
// No dependencies.
package ptc_pkg;

    // Field widths of the item ports
    localparam int REQ_W        = 2;
    localparam int NUMBER_W     = 16;
    localparam int RESULT_W     = 13;

    // Default operand width
    localparam int NUM_BITS_DEF = 16;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_TEST    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_COUNT   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FACTORS = 2'd2;

    // Counts saturate here
    localparam logic [RESULT_W-1:0] RESULT_MAX = '1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_TEST_CHECK,
        S_TEST_DIV,
        S_FACT_CHECK,
        S_FACT_DIV,
        S_FINISH
    } state_t;

endpackage

// ===== src/prime_test_and_count_unit.sv =====
// Prime test and count unit: trial division around one shared bit-serial divider.
// Depends on ptc_pkg (widths, request codes, state type).
//
// The unit takes one item (req_type, number) and returns one result. Type 0 tests
// number for primality (1 or 0), type 1 counts the primes up to number, type 2
// counts the distinct prime divisors of number; numbers below two and the unused
// type give 0, and counts saturate at the top of the result field. Only the low
// min(NUM_BITS, 16) bits of number take part. All work runs through one restoring
// divider that retires one quotient bit per cycle, so each trial divisor passes
// through one bound check, OP_W divide steps and one evaluation, where OP_W is the
// operand width. Type 2 spends one extra divide per repeated factor; type 1 repeats
// the test for every odd candidate up to number. in_stall stays high from acceptance
// until the result has been moved to the output register; that register holds the
// result until out_stall is low, and a new item may be taken meanwhile.
module prime_test_and_count_unit #(
    parameter int NUM_BITS = ptc_pkg::NUM_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [ptc_pkg::REQ_W-1:0]    req_type,
    input  logic [ptc_pkg::NUMBER_W-1:0] number,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [ptc_pkg::RESULT_W-1:0] result
);
    import ptc_pkg::*;

    // Operand width actually used
    localparam int OP_W  = (NUM_BITS < NUMBER_W) ? NUM_BITS : NUMBER_W;
    localparam int CNT_W = $clog2(OP_W + 1);
    localparam int SQ_W  = OP_W + 1;

    state_t               state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic [RESULT_W-1:0]  result_reg, result_next;
    logic [REQ_W-1:0]     kind_reg, kind_next;
    logic [OP_W-1:0]      n_reg, n_next;       // value under test / being reduced
    logic [OP_W-1:0]      lim_reg, lim_next;   // upper limit for prime counting
    logic [OP_W-1:0]      d_reg, d_next;       // trial divisor
    logic [SQ_W-1:0]      sq_reg, sq_next;     // d squared, kept incrementally
    logic [RESULT_W-1:0]  cnt_reg, cnt_next;
    logic                 hit_reg, hit_next;   // current divisor already counted
    logic [OP_W-1:0]      rem_reg, rem_next;
    logic [OP_W-1:0]      quo_reg, quo_next;
    logic [CNT_W-1:0]     div_cnt_reg, div_cnt_next;

    logic [OP_W:0]        rem_sh;
    logic [OP_W:0]        diff;
    logic [RESULT_W-1:0]  cnt_inc;
    logic [SQ_W-1:0]      sq_step;
    logic [OP_W-1:0]      op_in;
    logic                 verdict_en;
    logic                 verdict_prime;

    // Shared divider datapath: one restoring step
    assign rem_sh  = {rem_reg, quo_reg[OP_W-1]};
    assign diff    = rem_sh - {1'b0, d_reg};
    assign cnt_inc = (cnt_reg == RESULT_MAX) ? cnt_reg : cnt_reg + 1'b1;
    // (d+1)^2 = d^2 + 2d + 1
    assign sq_step = sq_reg + {d_reg, 1'b1};
    assign op_in   = number[OP_W-1:0];

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Sequencer: next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        kind_next      = kind_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        d_next         = d_reg;
        sq_next        = sq_reg;
        cnt_next       = cnt_reg;
        hit_next       = hit_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        verdict_en     = 1'b0;
        verdict_prime  = 1'b0;

        // output register drains when taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    kind_next = req_type;
                    n_next    = op_in;
                    lim_next  = op_in;
                    cnt_next  = '0;
                    hit_next  = 1'b0;
                    d_next    = OP_W'(2);
                    sq_next   = SQ_W'(4);
                    if (op_in < OP_W'(2))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        unique case (req_type)
                            REQ_TEST:
                            begin
                                state_next = S_TEST_CHECK;
                            end
                            REQ_COUNT:
                            begin
                                // the prime 2 is counted up front
                                cnt_next = RESULT_W'(1);
                                if (op_in < OP_W'(3))
                                begin
                                    state_next = S_FINISH;
                                end
                                else
                                begin
                                    n_next     = OP_W'(3);
                                    state_next = S_TEST_CHECK;
                                end
                            end
                            REQ_FACTORS:
                            begin
                                state_next = S_FACT_CHECK;
                            end
                            default:
                            begin
                                state_next = S_FINISH;
                            end
                        endcase
                    end
                end
            end

            // trial division bound, then start a divide
            S_TEST_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    verdict_en    = 1'b1;
                    verdict_prime = 1'b1;
                end
                else
                begin
                    quo_next     = n_reg;
                    rem_next     = '0;
                    div_cnt_next = CNT_W'(OP_W);
                    state_next   = S_TEST_DIV;
                end
            end

            S_TEST_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (diff[OP_W])
                    begin
                        rem_next = rem_sh[OP_W-1:0];
                        quo_next = {quo_reg[OP_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_next = diff[OP_W-1:0];
                        quo_next = {quo_reg[OP_W-2:0], 1'b1};
                    end
                end
                else if (rem_reg == '0)
                begin
                    verdict_en    = 1'b1;
                    verdict_prime = 1'b0;
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    sq_next    = sq_step;
                    state_next = S_TEST_CHECK;
                end
            end

            // factor loop bound; leftover above one is a prime factor
            S_FACT_CHECK:
            begin
                if (sq_reg > {1'b0, n_reg})
                begin
                    if (n_reg > OP_W'(1))
                    begin
                        cnt_next = cnt_inc;
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    quo_next     = n_reg;
                    rem_next     = '0;
                    div_cnt_next = CNT_W'(OP_W);
                    state_next   = S_FACT_DIV;
                end
            end

            S_FACT_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_cnt_next = div_cnt_reg - 1'b1;
                    if (diff[OP_W])
                    begin
                        rem_next = rem_sh[OP_W-1:0];
                        quo_next = {quo_reg[OP_W-2:0], 1'b0};
                    end
                    else
                    begin
                        rem_next = diff[OP_W-1:0];
                        quo_next = {quo_reg[OP_W-2:0], 1'b1};
                    end
                end
                else if (rem_reg == '0)
                begin
                    // divisor found: count once, strip it and divide again
                    if (!hit_reg)
                    begin
                        cnt_next = cnt_inc;
                    end
                    hit_next     = 1'b1;
                    n_next       = quo_reg;
                    rem_next     = '0;
                    div_cnt_next = CNT_W'(OP_W);
                end
                else
                begin
                    hit_next   = 1'b0;
                    d_next     = d_reg + 1'b1;
                    sq_next    = sq_step;
                    state_next = S_FACT_CHECK;
                end
            end

            // hand the result to the output register once it is free
            S_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    result_next    = cnt_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // primality verdict: finish a test, or move to the next odd candidate until the limit
        if (verdict_en)
        begin
            if (kind_reg == REQ_TEST)
            begin
                cnt_next   = {{(RESULT_W-1){1'b0}}, verdict_prime};
                state_next = S_FINISH;
            end
            else
            begin
                if (verdict_prime)
                begin
                    cnt_next = cnt_inc;
                end
                if (n_reg >= lim_reg - OP_W'(1))
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    n_next     = n_reg + OP_W'(2);
                    d_next     = OP_W'(2);
                    sq_next    = SQ_W'(4);
                    state_next = S_TEST_CHECK;
                end
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        result_reg  <= result_next;
        kind_reg    <= kind_next;
        n_reg       <= n_next;
        lim_reg     <= lim_next;
        d_reg       <= d_next;
        sq_reg      <= sq_next;
        cnt_reg     <= cnt_next;
        hit_reg     <= hit_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
    end

    // An accepted item always starts the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg != S_IDLE)
        else $error("accepted item did not start the sequencer");

    // Partial remainder stays below the divisor while dividing
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST_DIV || state_reg == S_FACT_DIV) |-> rem_reg < d_reg)
        else $error("divider remainder not below divisor");

    // Step counter never exceeds the operand width
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST_DIV || state_reg == S_FACT_DIV)
        |-> div_cnt_reg <= CNT_W'(OP_W))
        else $error("divider step count out of range");

    // Incremental square tracks the trial divisor
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST_CHECK || state_reg == S_FACT_CHECK)
        |-> ({OP_W'(0), d_reg} * {OP_W'(0), d_reg}) == (2 * OP_W)'(sq_reg))
        else $error("square register does not match divisor");

endmodule

// ===== tb/sv/ptc_result_checker.sv =====
// Result checker for the prime test and count unit: watches both item channels,
// predicts each result from the accepted request and compares in order.
// Depends on ptc_pkg (widths, request codes).
module ptc_result_checker #(
    parameter int NUM_BITS = ptc_pkg::NUM_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_stall,
    input  logic [ptc_pkg::REQ_W-1:0]    req_type,
    input  logic [ptc_pkg::NUMBER_W-1:0] number,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [ptc_pkg::RESULT_W-1:0] result,
    output int                           mismatches,
    output int                           outstanding,
    output int                           checked
);
    import ptc_pkg::*;

    // Only the low min(NUM_BITS, 16) bits of the number take part
    localparam int          OP_W    = (NUM_BITS < NUMBER_W) ? NUM_BITS : NUMBER_W;
    localparam int unsigned OP_MASK = (32'd1 << OP_W) - 32'd1;

    typedef struct {
        logic [REQ_W-1:0]    req;
        logic [NUMBER_W-1:0] num;
        logic [RESULT_W-1:0] answer;
    } pending_answer_t;

    pending_answer_t answer_q[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        checked     = 0;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Trial division up to the exact integer square root
    function automatic bit prime_by_trial(input int unsigned n);
        int unsigned d;
        if (n < 2) return 1'b0;
        for (d = 2; d * d <= n; d++)
        begin
            if (n % d == 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int unsigned primes_through(input int unsigned n);
        int unsigned k;
        int unsigned total;
        total = 0;
        for (k = 2; k <= n; k++)
        begin
            if (prime_by_trial(k)) total++;
        end
        return total;
    endfunction

    function automatic int unsigned distinct_divisors(input int unsigned n);
        int unsigned d;
        int unsigned rest;
        int unsigned total;
        total = 0;
        rest  = n;
        if (n < 2) return 0;
        for (d = 2; d * d <= rest; d++)
        begin
            if (rest % d == 0)
            begin
                total++;
                while (rest % d == 0) rest = rest / d;
            end
        end
        if (rest > 1) total++;
        return total;
    endfunction

    function automatic logic [RESULT_W-1:0] predict_answer(
        input logic [REQ_W-1:0]    req,
        input logic [NUMBER_W-1:0] num
    );
        int unsigned n;
        int unsigned r;
        n = int'(num) & OP_MASK;
        case (req)
            REQ_TEST:    r = prime_by_trial(n) ? 1 : 0;
            REQ_COUNT:   r = primes_through(n);
            REQ_FACTORS: r = distinct_divisors(n);
            default:     r = 0;
        endcase
        // counts wider than the field saturate
        if (r > int'(RESULT_MAX)) r = int'(RESULT_MAX);
        return r[RESULT_W-1:0];
    endfunction

    // Results are checked before requests are queued so a result in the same
    // cycle as a new request never matches that request
    always @(posedge clk)
    begin : watch_channels
        pending_answer_t head;
        pending_answer_t item;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_q.size() == 0)
                begin
                    report_mismatch($sformatf("result %0d with no request waiting", result));
                end
                else
                begin
                    head = answer_q.pop_front();
                    checked++;
                    if (result !== head.answer)
                    begin
                        report_mismatch($sformatf("req_type %0d number %0d: result %0d, want %0d",
                                                  head.req, head.num, result, head.answer));
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                item.req    = req_type;
                item.num    = number;
                item.answer = predict_answer(req_type, number);
                answer_q.push_back(item);
            end
            outstanding <= answer_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_prime_test_and_count_unit.sv =====
// Testbench top for the prime test and count unit: clock, reset, item stimulus,
// random stalls on the result side, watchdog and verdict.
// Depends on ptc_pkg, prime_test_and_count_unit and ptc_result_checker.
module tb_prime_test_and_count_unit;
    import ptc_pkg::*;

    // Request code the block does not use; it must answer 0
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    localparam int RAND_ITEMS     = 120;
    localparam int IDLE_PCT       = 30;
    localparam int QUIET_FIRST    = 60;
    localparam int QUIET_LAST     = 95;
    localparam int DRAIN_AT       = 110;
    localparam int WATCHDOG_LIMIT = 600000;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  out_stall = 1'b0;
    logic [REQ_W-1:0]      req_type  = REQ_TEST;
    logic [NUMBER_W-1:0]   number    = '0;
    logic                  in_stall;
    logic                  out_valid;
    logic [RESULT_W-1:0]   result;
    logic                  quiet     = 1'b0;

    int mismatches;
    int outstanding;
    int checked;
    int idle_cycles = 0;
    int sent_per_req[4] = '{0, 0, 0, 0};

    prime_test_and_count_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .req_type  (req_type),
        .number    (number),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    ptc_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .number      (number),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .result      (result),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Result side stalls at random except in the quiet stretch
    always @(posedge clk)
    begin
        out_stall <= rst_n && !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: cycles in which neither channel moves an item
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no item moved for %0d cycles", idle_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offer one item, with random idle cycles first, and wait until taken
    task automatic send_request(input logic [REQ_W-1:0] req, input logic [NUMBER_W-1:0] num);
        while (!quiet && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        req_type <= req;
        number   <= num;
        sent_per_req[req]++;
        do @(posedge clk); while (in_stall);
    endtask

    // Hold off the sender until every expected result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // Operands for the test and divisor requests: full range plus shaped values
    function automatic logic [NUMBER_W-1:0] pick_number();
        int unsigned small_primes[4] = '{2, 3, 5, 7};
        int unsigned v;
        int unsigned p;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: v = $urandom_range(0, 65535);
            5, 6:          v = $urandom_range(0, 300);
            7:             v = $urandom_range(65000, 65535);
            8:
            begin
                // prime power, so repeated factors show up
                p = small_primes[$urandom_range(0, 3)];
                v = p;
                while ((v * p <= 65535) && ($urandom_range(0, 3) != 0)) v = v * p;
            end
            default:       v = $urandom_range(2, 255) * $urandom_range(2, 255);
        endcase
        return v[NUMBER_W-1:0];
    endfunction

    initial
    begin
        int              i;
        int unsigned     sel;
        logic [NUMBER_W-1:0] num;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: edges of the operand, squares, prime powers, unused code
        send_request(REQ_TEST, 16'd0);
        send_request(REQ_TEST, 16'd1);
        send_request(REQ_TEST, 16'd2);
        send_request(REQ_TEST, 16'd3);
        send_request(REQ_TEST, 16'd4);
        send_request(REQ_TEST, 16'd63001);   // square of a prime: bound is i*i <= n
        send_request(REQ_TEST, 16'd65521);   // largest 16-bit prime
        send_request(REQ_TEST, 16'd65535);
        send_request(REQ_COUNT, 16'd0);
        send_request(REQ_COUNT, 16'd1);
        send_request(REQ_COUNT, 16'd2);
        send_request(REQ_COUNT, 16'd3);
        send_request(REQ_COUNT, 16'd10);
        send_request(REQ_COUNT, 16'd1000);
        send_request(REQ_FACTORS, 16'd0);
        send_request(REQ_FACTORS, 16'd1);
        send_request(REQ_FACTORS, 16'd2);
        send_request(REQ_FACTORS, 16'd30030);  // six distinct small primes
        send_request(REQ_FACTORS, 16'd32768);  // one prime, many times
        send_request(REQ_FACTORS, 16'd65521);
        send_request(REQ_FACTORS, 16'd65535);
        send_request(REQ_UNUSED, 16'd0);
        send_request(REQ_UNUSED, 16'd65535);
        drain_results();

        // Random: counting requests stay small, they cost far more cycles
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            quiet <= (i >= QUIET_FIRST) && (i < QUIET_LAST);
            if (i == DRAIN_AT) drain_results();
            sel = $urandom_range(0, 99);
            if (sel < 40)
            begin
                send_request(REQ_TEST, pick_number());
            end
            else if (sel < 75)
            begin
                send_request(REQ_FACTORS, pick_number());
            end
            else if (sel < 95)
            begin
                num = ($urandom_range(0, 9) == 0) ? NUMBER_W'($urandom_range(201, 600))
                                                  : NUMBER_W'($urandom_range(0, 200));
                send_request(REQ_COUNT, num);
            end
            else
            begin
                num = NUMBER_W'($urandom_range(0, 65535));
                send_request(REQ_UNUSED, num);
            end
        end

        // Drain and let the output register settle
        drain_results();
        repeat (40) @(posedge clk);

        $display("covered %0d tests, %0d prime counts, %0d divisor counts, %0d unused codes",
                 sent_per_req[REQ_TEST], sent_per_req[REQ_COUNT],
                 sent_per_req[REQ_FACTORS], sent_per_req[REQ_UNUSED]);
        $display("%0d results checked under random stalls, %0d mismatches", checked, mismatches);
        if (mismatches == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
